// ----- design/mux_frame_deframer_macros.svh -----
// Assertion macros for the mux frame deframer.
// Uses clk_i and rst_ni of the module that includes this header.
`ifndef MUX_FRAME_DEFRAMER_MACROS_SVH
`define MUX_FRAME_DEFRAMER_MACROS_SVH

`ifndef SYNTHESIS
`define MFD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("mux_frame_deframer assertion failed");
`define MFD_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("mux_frame_deframer assertion failed");
`else
`define MFD_ASSERT(lbl, prop)
`define MFD_ASSERT_RST(lbl, prop)
`endif

`endif

// ----- design/mfd_pkg.sv -----
// Shared constants for the mux frame deframer.
// No dependencies.
`timescale 1ns / 1ps

package mfd_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned LenW      = 10;
  localparam int unsigned FlagW     = 6;
  localparam int unsigned ApbDataW  = 32;
  localparam int unsigned ApbAddrW  = 3;

  localparam logic [LenW-1:0]  MaxPayloadRst = 10'd1023;
  localparam logic [ByteW-1:0] TrailerXor    = 8'hFF;

  // register word index, taken from paddr[2]
  localparam logic RegMaxPayload = 1'b0;

endpackage

// ----- design/mux_frame_deframer.sv -----
// Mux link frame deframer: byte-wide frame parser with an APB control port.
// Depends on mfd_pkg and mux_frame_deframer_macros.svh.
`timescale 1ns / 1ps
`include "mux_frame_deframer_macros.svh"

// Takes one received byte per word and parses start, link id, flags/length-high,
// length-low, payload and trailer. Each payload byte is returned as one word;
// the trailer yields one end word with the header fields and a link check.
// Frames longer than max_payload are consumed silently and reported with
// length zero and dropped set. One input word per clock cycle: the phase logic
// sits between the parser state and a single output register, and input is
// stalled only while that register holds a word the sink is stalling.
module mux_frame_deframer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [mfd_pkg::ByteW-1:0]         rx_byte_i,
  // output channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              is_end_o,
  output logic [mfd_pkg::ByteW-1:0]         payload_byte_o,
  output logic [mfd_pkg::ByteW-1:0]         start_byte_o,
  output logic [mfd_pkg::ByteW-1:0]         link_number_o,
  output logic [mfd_pkg::FlagW-1:0]         flag_bits_o,
  output logic [mfd_pkg::LenW-1:0]          frame_length_o,
  output logic                              dropped_o,
  output logic                              link_error_o,
  // APB config port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mfd_pkg::ApbAddrW-1:0]      paddr,
  input  logic [mfd_pkg::ApbDataW-1:0]      pwdata,
  output logic [mfd_pkg::ApbDataW-1:0]      prdata,
  output logic                              pready
);

  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_LINK    = 3'd1,
    PH_FLAGS   = 3'd2,
    PH_LENLO   = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_TRAILER = 3'd5
  } phase_e;

  phase_e                    phase_q, phase_d;
  logic [mfd_pkg::LenW-1:0]  max_payload_q;
  logic [mfd_pkg::ByteW-1:0] held_start_q, held_start_d;
  logic [mfd_pkg::ByteW-1:0] held_link_q, held_link_d;
  logic [mfd_pkg::FlagW-1:0] held_flags_q, held_flags_d;
  logic [1:0]                len_hi_q, len_hi_d;
  logic [mfd_pkg::LenW-1:0]  held_length_q, held_length_d;
  logic [mfd_pkg::LenW-1:0]  bytes_left_q, bytes_left_d;
  logic                      discard_q, discard_d;

  logic                      out_valid_q;
  logic                      is_end_q, is_end_d;
  logic [mfd_pkg::ByteW-1:0] payload_q, payload_d;
  logic [mfd_pkg::ByteW-1:0] start_q, start_d;
  logic [mfd_pkg::ByteW-1:0] link_q, link_d;
  logic [mfd_pkg::FlagW-1:0] flags_q, flags_d;
  logic [mfd_pkg::LenW-1:0]  length_q, length_d;
  logic                      dropped_q, dropped_d;
  logic                      link_err_q, link_err_d;

  logic                      in_acc;
  logic                      emit;
  logic                      cfg_wr;
  logic [mfd_pkg::LenW-1:0]  len_full;
  logic [mfd_pkg::LenW-1:0]  left_dec;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign pready     = 1'b1;
  assign prdata     = (paddr[2] == mfd_pkg::RegMaxPayload)
                      ? {{(mfd_pkg::ApbDataW-mfd_pkg::LenW){1'b0}}, max_payload_q}
                      : '0;

  assign len_full = {len_hi_q, rx_byte_i};
  assign left_dec = bytes_left_q - 10'd1;

  always_comb begin
    phase_d       = phase_q;
    held_start_d  = held_start_q;
    held_link_d   = held_link_q;
    held_flags_d  = held_flags_q;
    len_hi_d      = len_hi_q;
    held_length_d = held_length_q;
    bytes_left_d  = bytes_left_q;
    discard_d     = discard_q;
    emit          = 1'b0;
    is_end_d      = 1'b0;
    payload_d     = '0;
    start_d       = '0;
    link_d        = '0;
    flags_d       = '0;
    length_d      = '0;
    dropped_d     = 1'b0;
    link_err_d    = 1'b0;
    unique case (phase_q)
      PH_LINK: begin
        held_link_d = rx_byte_i;
        phase_d     = PH_FLAGS;
      end
      PH_FLAGS: begin
        held_flags_d = rx_byte_i[7:2];
        len_hi_d     = rx_byte_i[1:0];
        phase_d      = PH_LENLO;
      end
      PH_LENLO: begin
        held_length_d = len_full;
        bytes_left_d  = len_full;
        discard_d     = (len_full > max_payload_q);
        phase_d       = (len_full == '0) ? PH_TRAILER : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        bytes_left_d = left_dec;
        if (left_dec == '0) begin
          phase_d = PH_TRAILER;
        end
        emit      = !discard_q;
        payload_d = rx_byte_i;
      end
      PH_TRAILER: begin
        emit         = 1'b1;
        is_end_d     = 1'b1;
        start_d      = held_start_q;
        link_d       = held_link_q;
        flags_d      = held_flags_q;
        length_d     = discard_q ? '0 : held_length_q;
        dropped_d    = discard_q;
        link_err_d   = ((held_link_q ^ rx_byte_i) != mfd_pkg::TrailerXor);
        phase_d      = PH_START;
        discard_d    = 1'b0;
        bytes_left_d = '0;
      end
      default: begin
        held_start_d = rx_byte_i;
        phase_d      = PH_LINK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_START;
      max_payload_q <= mfd_pkg::MaxPayloadRst;
      bytes_left_q  <= '0;
      discard_q     <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_wr && (paddr[2] == mfd_pkg::RegMaxPayload)) begin
        max_payload_q <= pwdata[mfd_pkg::LenW-1:0];
      end
      if (in_acc) begin
        phase_q      <= phase_d;
        bytes_left_q <= bytes_left_d;
        discard_q    <= discard_d;
      end
      if (in_acc && emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      held_start_q  <= held_start_d;
      held_link_q   <= held_link_d;
      held_flags_q  <= held_flags_d;
      len_hi_q      <= len_hi_d;
      held_length_q <= held_length_d;
    end
    if (in_acc && emit) begin
      is_end_q   <= is_end_d;
      payload_q  <= payload_d;
      start_q    <= start_d;
      link_q     <= link_d;
      flags_q    <= flags_d;
      length_q   <= length_d;
      dropped_q  <= dropped_d;
      link_err_q <= link_err_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign is_end_o       = is_end_q;
  assign payload_byte_o = payload_q;
  assign start_byte_o   = start_q;
  assign link_number_o  = link_q;
  assign flag_bits_o    = flags_q;
  assign frame_length_o = length_q;
  assign dropped_o      = dropped_q;
  assign link_error_o   = link_err_q;

  `MFD_ASSERT(a_payload_left, (phase_q == PH_PAYLOAD) |-> (bytes_left_q != '0))
  `MFD_ASSERT(a_discard_silent,
      (in_acc && (phase_q == PH_PAYLOAD) && discard_q && !out_valid_q) |=> !out_valid_q)
  `MFD_ASSERT(a_drop_len_zero,
      (out_valid_q && dropped_q) |-> (is_end_q && (length_q == '0)))
  `MFD_ASSERT(a_end_phase,
      (in_acc && (phase_q == PH_TRAILER)) |=> (phase_q == PH_START) && !discard_q)
  `MFD_ASSERT_RST(a_stall_reset, !rst_ni |-> !in_stall_o)

endmodule

// ----- tb/sv/mux_frame_deframer_tb.sv -----
// Self-checking testbench for mux_frame_deframer: byte stream in, payload and end words out.
// Depends on mfd_pkg and the mux_frame_deframer RTL; a scoreboard class predicts each word.
`timescale 1ns / 1ps

typedef enum logic [2:0] {
  WaitStart, WaitLink, WaitFlags, WaitLenLo, InPayload, WaitTrailer
} parse_phase_e;

typedef struct packed {
  logic                      is_end;
  logic [mfd_pkg::ByteW-1:0] payload_byte;
  logic [mfd_pkg::ByteW-1:0] start_byte;
  logic [mfd_pkg::ByteW-1:0] link_number;
  logic [mfd_pkg::FlagW-1:0] flag_bits;
  logic [mfd_pkg::LenW-1:0]  frame_length;
  logic                      dropped;
  logic                      link_error;
} frame_word_t;

class deframer_scoreboard;
  parse_phase_e              phase;
  logic [mfd_pkg::ByteW-1:0] start_q;
  logic [mfd_pkg::ByteW-1:0] link_q;
  logic [mfd_pkg::FlagW-1:0] flags_q;
  logic [mfd_pkg::LenW-1:0]  length_q;
  logic [mfd_pkg::LenW-1:0]  remaining;
  bit                        discarding;
  logic [mfd_pkg::LenW-1:0]  max_payload;
  frame_word_t               expected_words[$];
  int unsigned               mismatches;

  function new();
    phase       = WaitStart;
    start_q     = '0;
    link_q      = '0;
    flags_q     = '0;
    length_q    = '0;
    remaining   = '0;
    discarding  = 1'b0;
    max_payload = mfd_pkg::MaxPayloadRst;
    mismatches  = 0;
  endfunction

  function void set_max_payload(logic [mfd_pkg::LenW-1:0] value);
    max_payload = value;
  endfunction

  function int pending();
    return expected_words.size();
  endfunction

  // advances the frame parser by one accepted byte
  function void parse_rx_byte(logic [mfd_pkg::ByteW-1:0] b);
    frame_word_t w;
    w = '0;
    case (phase)
      WaitLink: begin
        link_q = b;
        phase  = WaitFlags;
      end
      WaitFlags: begin
        flags_q  = b[7:2];
        length_q = {b[1:0], 8'h00};
        phase    = WaitLenLo;
      end
      WaitLenLo: begin
        length_q[7:0] = b;
        discarding    = (length_q > max_payload);
        remaining     = length_q;
        phase         = (length_q == '0) ? WaitTrailer : InPayload;
      end
      InPayload: begin
        remaining = remaining - 1'b1;
        if (remaining == '0) phase = WaitTrailer;
        if (!discarding) begin
          w.payload_byte = b;
          expected_words.push_back(w);
        end
      end
      WaitTrailer: begin
        w.is_end       = 1'b1;
        w.start_byte   = start_q;
        w.link_number  = link_q;
        w.flag_bits    = flags_q;
        w.frame_length = discarding ? '0 : length_q;
        w.dropped      = discarding;
        w.link_error   = ((link_q ^ b) != mfd_pkg::TrailerXor);
        expected_words.push_back(w);
        phase      = WaitStart;
        discarding = 1'b0;
        remaining  = '0;
      end
      default: begin
        start_q = b;
        phase   = WaitLink;
      end
    endcase
  endfunction

  function void check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
      mismatches++;
    end
  endfunction

  function void check_deframed_word(frame_word_t got);
    frame_word_t want;
    if (expected_words.size() == 0) begin
      $error("output word with none expected: 0x%0h", got);
      mismatches++;
      return;
    end
    want = expected_words.pop_front();
    check_field("is_end", want.is_end, got.is_end);
    check_field("payload_byte", want.payload_byte, got.payload_byte);
    check_field("start_byte", want.start_byte, got.start_byte);
    check_field("link_number", want.link_number, got.link_number);
    check_field("flag_bits", want.flag_bits, got.flag_bits);
    check_field("frame_length", want.frame_length, got.frame_length);
    check_field("dropped", want.dropped, got.dropped);
    check_field("link_error", want.link_error, got.link_error);
  endfunction
endclass

module mux_frame_deframer_tb;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldCycles = 200;
  localparam logic [mfd_pkg::ApbAddrW-1:0] MaxPayloadAddr = {mfd_pkg::RegMaxPayload, 2'b00};

  logic                         clk_i        = 1'b0;
  logic                         rst_ni       = 1'b0;
  logic                         in_valid_i   = 1'b0;
  logic                         in_stall_o;
  logic [mfd_pkg::ByteW-1:0]    rx_byte_i    = '0;
  logic                         out_valid_o;
  logic                         out_stall_i  = 1'b0;
  logic                         is_end_o;
  logic [mfd_pkg::ByteW-1:0]    payload_byte_o;
  logic [mfd_pkg::ByteW-1:0]    start_byte_o;
  logic [mfd_pkg::ByteW-1:0]    link_number_o;
  logic [mfd_pkg::FlagW-1:0]    flag_bits_o;
  logic [mfd_pkg::LenW-1:0]     frame_length_o;
  logic                         dropped_o;
  logic                         link_error_o;
  logic                         psel         = 1'b0;
  logic                         penable      = 1'b0;
  logic                         pwrite       = 1'b0;
  logic [mfd_pkg::ApbAddrW-1:0] paddr        = '0;
  logic [mfd_pkg::ApbDataW-1:0] pwdata       = '0;
  logic [mfd_pkg::ApbDataW-1:0] prdata;
  logic                         pready;

  deframer_scoreboard        sb = new();
  logic [mfd_pkg::ByteW-1:0] link_bytes[$];
  int unsigned               send_idle = 14;
  int unsigned               recv_idle = 70;
  bit                        pressure_armed = 1'b0;
  int unsigned               cycle_count = 0;

  mux_frame_deframer i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .is_end_o       (is_end_o),
    .payload_byte_o (payload_byte_o),
    .start_byte_o   (start_byte_o),
    .link_number_o  (link_number_o),
    .flag_bits_o    (flag_bits_o),
    .frame_length_o (frame_length_o),
    .dropped_o      (dropped_o),
    .link_error_o   (link_error_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_byte(logic [mfd_pkg::ByteW-1:0] b);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    sb.parse_rx_byte(b);
  endtask

  // waits until no word is pending, then idles so that bytes that make no word are taken
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [mfd_pkg::ApbAddrW-1:0] addr,
                           logic [mfd_pkg::ApbDataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_max_payload(data[mfd_pkg::LenW-1:0]);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic void queue_frame();
    int unsigned               r;
    int unsigned               len;
    logic [mfd_pkg::ByteW-1:0] link;
    r    = $urandom_range(99);
    len  = (r < 85) ? $urandom_range(0, 12) :
           (r < 97) ? $urandom_range(13, 80) : $urandom_range(81, 1023);
    link = 8'($urandom_range(255));
    link_bytes.push_back(8'($urandom_range(255)));
    link_bytes.push_back(link);
    link_bytes.push_back({6'($urandom_range(63)), 2'(len >> 8)});
    link_bytes.push_back(len[7:0]);
    repeat (len) link_bytes.push_back(8'($urandom_range(255)));
    link_bytes.push_back(($urandom_range(99) < 80) ? ~link : 8'($urandom_range(255)));
  endfunction

  // receiver: checks accepted words and drives stall, with one long hold-off
  initial begin : receiver
    int unsigned hold_left;
    bit          held_once;
    frame_word_t got;
    hold_left = 0;
    held_once = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        got.is_end       = is_end_o;
        got.payload_byte = payload_byte_o;
        got.start_byte   = start_byte_o;
        got.link_number  = link_number_o;
        got.flag_bits    = flag_bits_o;
        got.frame_length = frame_length_o;
        got.dropped      = dropped_o;
        got.link_error   = link_error_o;
        sb.check_deframed_word(got);
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (pressure_armed && !held_once && out_valid_o) begin
        held_once = 1'b1;
        hold_left = HoldCycles - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle);
      end
    end
  end

  initial begin : stimulus
    int unsigned      chunk_items[4];
    int unsigned      chunk_max[4];
    int unsigned      chunk_send_idle[4];
    int unsigned      chunk_recv_idle[4];
    chunk_items     = '{450, 250, 450, 300};
    chunk_max       = '{1023, 0, $urandom_range(8, 60), $urandom_range(1, 1022)};
    chunk_send_idle = '{14, 70, 0, 0};
    chunk_recv_idle = '{70, 14, 0, 0};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero length, fitting payload at the limit, and an over-long frame with a bad trailer
    apb_write(MaxPayloadAddr, 2);
    link_bytes = '{8'hFF, 8'hFF, 8'hFC, 8'h00, 8'h00,
                   8'h00, 8'h00, 8'h00, 8'h02, 8'hAA, 8'h55, 8'hFF,
                   8'h7E, 8'h5A, 8'h80, 8'h03, 8'h11, 8'h22, 8'h33, 8'h00};
    while (link_bytes.size() != 0) send_byte(link_bytes.pop_front());

    // chunks may end mid-frame, so the register also changes inside a frame
    for (int c = 0; c < 4; c++) begin
      drain();
      send_idle = chunk_send_idle[c];
      recv_idle = chunk_recv_idle[c];
      pressure_armed = (c == 2);
      apb_write(MaxPayloadAddr, chunk_max[c]);
      repeat (chunk_items[c]) begin
        if (link_bytes.size() == 0) queue_frame();
        send_byte(link_bytes.pop_front());
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- mux_frame_deframer.f -----
+incdir+design
design/mfd_pkg.sv
design/mux_frame_deframer.sv
tb/sv/mux_frame_deframer_tb.sv
